### sv/mear_pkg.sv
// ----------------------------------------------------------------------------
// mear_pkg - shared types and constants for the mesh element aspect ratio block
// Widths of the fixed-point datapath, payload structs and the element modes.
// ----------------------------------------------------------------------------
package mear_pkg;

    localparam int COORD_WIDTH = 32;               // used low bits of a coordinate
    localparam int FRAC_BITS   = 16;               // fraction bits of the ratio
    localparam int RATIO_W     = 32;
    localparam int DIAM_W      = 31;
    localparam int QW          = 2 * RATIO_W;      // quotient bits before the root
    localparam int SH          = QW - 2 * FRAC_BITS;
    localparam int DFW         = COORD_WIDTH + 1;  // coordinate difference
    localparam int SQW         = 2 * DFW;          // product of two differences
    localparam int D2W         = SQW + 2;          // sum of three squares
    localparam int HW          = D2W / 2;          // half word for split squaring
    localparam int NW          = 2 * D2W;          // numerator
    localparam int DENW        = NW + 2;           // denominator (sum of three)
    localparam int XW          = NW + 2 * FRAC_BITS;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        MODE_TRI  = 2'd0,
        MODE_RECT = 2'd1,
        MODE_LINE = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] z0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] z1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] z2;
        logic [DIAM_W-1:0] diameter;
    } in_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               degenerate;
    } out_t;

    // squared ratio num/den handed from the front to the back
    typedef struct packed {
        logic [NW-1:0]   num;
        logic [DENW-1:0] den;
        logic            bad;
    } entry_t;

    function automatic logic signed [DFW-1:0] sx(input logic [31:0] c);
        return {c[COORD_WIDTH-1], c[COORD_WIDTH-1:0]};
    endfunction

endpackage

### sv/mear_front.sv
// ----------------------------------------------------------------------------
// mear_front - element classification front end
// Forms the squared ratio num/den for each element mode over seven stages.
// ----------------------------------------------------------------------------
module mear_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mear_pkg::in_t    item,
    output logic            q_push,
    output mear_pkg::entry_t q_entry,
    input  logic            q_full
);
    import mear_pkg::*;

    function automatic logic signed [SQW-1:0] smul(input logic signed [DFW-1:0] a,
                                                   input logic signed [DFW-1:0] b);
        return SQW'(a) * SQW'(b);
    endfunction

    logic        en;
    logic [7:1]  v_reg;
    logic [7:1]  v_next;

    logic signed [DFW-1:0] p0[3], p1[3], p2[3];

    // stage 1: differences
    logic signed [DFW-1:0] u_reg[3], w_reg[3], e_reg[3];
    mode_t                 mode_reg[1:6];
    logic [DIAM_W-1:0]     dia_reg;
    // stage 2: products
    logic [SQW-1:0]        su_reg[3], sw_reg[3];
    logic [SQW-1:0]        se_reg[3];
    logic signed [SQW-1:0] cp_reg[6];
    logic [2*DIAM_W-1:0]   dd_reg[2:6];
    // stage 3: sums
    logic [D2W-1:0]        a_reg, b_reg, c_reg;
    logic signed [SQW:0]   cr_reg[3];
    // stage 4: max, magnitudes
    logic [D2W-1:0]        l_reg, crm_reg[3];
    logic [D2W-1:0]        rmax_reg[4:6], rmin_reg[4:6], ln_reg[4:6];
    // stage 5: partial products of the four squares
    logic [2*HW-1:0]       ll_reg[4], lh_reg[4], hh_reg[4];
    // stage 6: squares
    logic [NW-1:0]         sq_reg[4];
    // stage 7: queue entry
    entry_t                ent_reg;

    logic [D2W-1:0]        sqin[4];
    entry_t                ent_next;
    logic [DENW-1:0]       area;

    assign en     = !(v_reg[7] && q_full);
    assign full   = !en;
    assign q_push = v_reg[7] && !q_full;
    assign q_entry = ent_reg;
    assign v_next = {v_reg[6:1], push};

    assign p0[0] = sx(item.x0);
    assign p0[1] = sx(item.y0);
    assign p0[2] = sx(item.z0);
    assign p1[0] = sx(item.x1);
    assign p1[1] = sx(item.y1);
    assign p1[2] = sx(item.z1);
    assign p2[0] = sx(item.x2);
    assign p2[1] = sx(item.y2);
    assign p2[2] = sx(item.z2);

    assign sqin[0] = l_reg;
    assign sqin[1] = crm_reg[0];
    assign sqin[2] = crm_reg[1];
    assign sqin[3] = crm_reg[2];

    always_comb
    begin
        area = DENW'(sq_reg[1]) + DENW'(sq_reg[2]) + DENW'(sq_reg[3]);
        unique case (mode_reg[6])
            MODE_TRI:
            begin
                ent_next.num = sq_reg[0];
                ent_next.den = area;
            end
            MODE_RECT:
            begin
                ent_next.num = NW'(rmax_reg[6]);
                ent_next.den = DENW'(rmin_reg[6]);
            end
            MODE_LINE:
            begin
                ent_next.num = NW'(ln_reg[6]);
                ent_next.den = DENW'(dd_reg[6]);
            end
            default:
            begin
                ent_next.num = '0;
                ent_next.den = '0;
            end
        endcase
        ent_next.bad = (ent_next.den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= p1[i] - p0[i];
                w_reg[i] <= p2[i] - p0[i];
                e_reg[i] <= p2[i] - p1[i];
                su_reg[i] <= SQW'(smul(u_reg[i], u_reg[i]));
                sw_reg[i] <= SQW'(smul(w_reg[i], w_reg[i]));
            end
            mode_reg[1] <= mode_t'(item.mode);
            dia_reg     <= item.diameter;

            // stage 2: sw holds |P2-P0|^2 terms, e terms fold into c below
            cp_reg[0] <= smul(u_reg[1], w_reg[2]);
            cp_reg[1] <= smul(u_reg[2], w_reg[1]);
            cp_reg[2] <= smul(u_reg[2], w_reg[0]);
            cp_reg[3] <= smul(u_reg[0], w_reg[2]);
            cp_reg[4] <= smul(u_reg[0], w_reg[1]);
            cp_reg[5] <= smul(u_reg[1], w_reg[0]);
            dd_reg[2] <= dia_reg * dia_reg;
            mode_reg[2] <= mode_reg[1];

            // stage 3
            a_reg <= D2W'(su_reg[0]) + D2W'(su_reg[1]) + D2W'(su_reg[2]);
            b_reg <= D2W'(sw_reg[0]) + D2W'(sw_reg[1]) + D2W'(sw_reg[2]);
            c_reg <= D2W'(se_reg[0]) + D2W'(se_reg[1]) + D2W'(se_reg[2]);
            cr_reg[0] <= (SQW+1)'(cp_reg[0]) - (SQW+1)'(cp_reg[1]);
            cr_reg[1] <= (SQW+1)'(cp_reg[2]) - (SQW+1)'(cp_reg[3]);
            cr_reg[2] <= (SQW+1)'(cp_reg[4]) - (SQW+1)'(cp_reg[5]);
            dd_reg[3] <= dd_reg[2];
            mode_reg[3] <= mode_reg[2];

            // stage 4
            if (a_reg >= b_reg && a_reg >= c_reg)
                l_reg <= a_reg;
            else if (b_reg >= c_reg)
                l_reg <= b_reg;
            else
                l_reg <= c_reg;
            for (int i = 0; i < 3; i++)
                crm_reg[i] <= cr_reg[i][SQW] ? D2W'(-cr_reg[i]) : D2W'(cr_reg[i]);
            rmax_reg[4] <= (a_reg >= b_reg) ? a_reg : b_reg;
            rmin_reg[4] <= (a_reg >= b_reg) ? b_reg : a_reg;
            ln_reg[4]   <= a_reg;
            dd_reg[4]   <= dd_reg[3];
            mode_reg[4] <= mode_reg[3];

            // stage 5: s^2 = hh<<2H + 2*lh<<H + ll
            for (int k = 0; k < 4; k++)
            begin
                ll_reg[k] <= sqin[k][HW-1:0] * sqin[k][HW-1:0];
                lh_reg[k] <= sqin[k][HW-1:0] * sqin[k][D2W-1:HW];
                hh_reg[k] <= sqin[k][D2W-1:HW] * sqin[k][D2W-1:HW];
            end

            // stage 6
            for (int k = 0; k < 4; k++)
                sq_reg[k] <= (NW'(hh_reg[k]) << (2 * HW)) + (NW'(lh_reg[k]) << (HW + 1))
                           + NW'(ll_reg[k]);

            for (int s = 5; s <= 6; s++)
            begin
                rmax_reg[s] <= rmax_reg[s-1];
                rmin_reg[s] <= rmin_reg[s-1];
                ln_reg[s]   <= ln_reg[s-1];
                dd_reg[s]   <= dd_reg[s-1];
                mode_reg[s] <= mode_reg[s-1];
            end

            // stage 7
            ent_reg <= ent_next;
        end
    end

    // squares of P2-P1 for the third side
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                se_reg[i] <= SQW'(smul(e_reg[i], e_reg[i]));
        end
    end

endmodule

### sv/mear_queue.sv
// ----------------------------------------------------------------------------
// mear_queue - short queue between front and back
// Register-based FIFO of QDEPTH entries.
// ----------------------------------------------------------------------------
module mear_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  mear_pkg::entry_t wdata,
    output logic             full,
    input  logic             rd,
    output mear_pkg::entry_t rdata,
    output logic             valid
);
    import mear_pkg::*;

    entry_t         mem_reg[QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

### sv/mear_back.sv
// ----------------------------------------------------------------------------
// mear_back - divide and square root back end
// One quotient bit per stage, then one root bit per stage, then saturation.
// ----------------------------------------------------------------------------
module mear_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  mear_pkg::entry_t q_entry,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output mear_pkg::out_t   result
);
    import mear_pkg::*;

    localparam int BL = QW + RATIO_W + 1;

    logic            en;
    logic [BL-1:0]   bv_reg, bb_reg;
    logic            out_v_reg;
    out_t            result_reg;

    logic [XW-1:0]   xf;
    logic [DENW-1:0] nh;
    logic            bad0;

    logic [DENW-1:0] dr_reg[QW+1];
    logic [DENW-1:0] dd_reg[QW+1];
    logic [QW-1:0]   dx_reg[QW+1];
    logic [QW-1:0]   dq_reg[QW+1];
    logic [QW-1:0]   sx_reg[RATIO_W];
    logic [QW-1:0]   sr_reg[RATIO_W];

    assign en     = !out_v_reg || pop;
    assign q_pop  = en && q_valid;
    assign empty  = !out_v_reg;
    assign result = result_reg;

    // quotient fits QW bits only when num >> SH < den
    assign xf   = XW'(q_entry.num) << (2 * FRAC_BITS);
    assign nh   = DENW'(xf[XW-1:QW]);
    assign bad0 = q_entry.bad || (nh >= q_entry.den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            bv_reg    <= {bv_reg[BL-2:0], q_valid};
            out_v_reg <= bv_reg[BL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg    <= {bb_reg[BL-2:0], bad0};
            dr_reg[0] <= nh;
            dd_reg[0] <= q_entry.den;
            dx_reg[0] <= xf[QW-1:0];
            dq_reg[0] <= '0;
            result_reg.ratio      <= bb_reg[BL-1] ? '1 : sr_reg[RATIO_W-1][RATIO_W-1:0];
            result_reg.degenerate <= bb_reg[BL-1];
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DENW:0] t;
        logic          ge;
        assign t  = {dr_reg[k], dx_reg[k][QW-1]};
        assign ge = (t >= (DENW+1)'(dd_reg[k]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dr_reg[k+1] <= ge ? DENW'(t - (DENW+1)'(dd_reg[k])) : DENW'(t);
                dd_reg[k+1] <= dd_reg[k];
                dx_reg[k+1] <= dx_reg[k] << 1;
                dq_reg[k+1] <= {dq_reg[k][QW-2:0], ge};
            end
        end
    end

    for (genvar j = 0; j < RATIO_W; j++)
    begin : g_root
        localparam logic [QW-1:0] BITC = QW'(1) << (QW - 2 - 2 * j);
        logic [QW-1:0] xin, rin;
        logic [QW:0]   sum;
        logic          ge;
        if (j == 0)
        begin : g_first
            assign xin = dq_reg[QW];
            assign rin = '0;
        end
        else
        begin : g_next
            assign xin = sx_reg[j-1];
            assign rin = sr_reg[j-1];
        end
        assign sum = (QW+1)'(rin) + (QW+1)'(BITC);
        assign ge  = ((QW+1)'(xin) >= sum);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sx_reg[j] <= ge ? xin - sum[QW-1:0] : xin;
                sr_reg[j] <= ge ? (rin >> 1) + BITC : rin >> 1;
            end
        end
    end

endmodule

### sv/mesh_element_aspect_ratio.sv
// ----------------------------------------------------------------------------
// mesh_element_aspect_ratio - aspect ratio of triangles, rectangles, lines
// Top level: front end, queue and divide/root back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a transfer happens on a rising edge
//   with push high and full low. item carries the mode, three vertices in
//   signed Q16.16 and the line diameter.
//   Output side is a queue read port: while empty is low, result holds the
//   oldest ratio (unsigned Q16.16) and degenerate flag; pop takes it.
//   From input transfer to the result showing, an element passes 7 front
//   stages forming the squared ratio, one queue stage, an input register,
//   then a 64-stage restoring divider (one quotient bit per stage), a
//   32-stage square root (one root bit per stage) and the output register.
//   Throughput is one element per cycle while pop keeps up.
//   When the receiver stalls, the back pipeline holds; the front keeps
//   going until the 4-entry queue fills, then full rises.
//   Reset empties every stage and the queue; no state survives otherwise.
//   Zero denominators, unused mode 3 and ratios of 2^32 raw or more give
//   ratio all ones with degenerate set.
// ----------------------------------------------------------------------------
module mesh_element_aspect_ratio (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  mear_pkg::in_t  item,
    output logic           empty,
    input  logic           pop,
    output mear_pkg::out_t result
);
    import mear_pkg::*;

    logic   q_push, q_full, q_pop, q_valid;
    entry_t q_wdata, q_rdata;

    mear_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_push  (q_push),
        .q_entry (q_wdata),
        .q_full  (q_full)
    );

    mear_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    mear_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### sv/mear_chk.sv
// ----------------------------------------------------------------------------
// mear_chk - port checker for the aspect ratio block
// Watches both queue ports; bound to the top level.
// ----------------------------------------------------------------------------
module mear_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           push,
    input logic           full,
    input mear_pkg::in_t  item,
    input logic           empty,
    input logic           pop,
    input mear_pkg::out_t result
);
    import mear_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without transfer");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("result changed while stalled");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.degenerate) |-> (result.ratio == '1))
        else $error("degenerate result not saturated");

    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(!empty && !pop))
        else $error("full without output stall");

    logic unused_in;
    assign unused_in = push ^ (^item);

endmodule

bind mesh_element_aspect_ratio mear_chk u_chk (.*);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for mesh_element_aspect_ratio
// Elements queued by an initial block feed a clocked driver. A clocked monitor
// pops results and compares each with the aspect ratio worked out by a wide
// integer predictor when the element's transfer was seen.
// ----------------------------------------------------------------------------
module tb_top;
    import mear_pkg::*;

    // wide enough for L^4 << 32 (about 170 bits)
    typedef logic [199:0] wide_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_t  item;
    logic empty;
    logic pop;
    out_t result;

    in_t  pending_elems[$];
    out_t ratio_queue[$];
    bit   failed;
    bit   calm;       // no idling on either side while set
    bit   taken;      // driver's item moved on the last rising edge

    mesh_element_aspect_ratio u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    // floor of the square root of a 64-bit value, one root bit at a time
    function automatic logic [31:0] root64(input logic [63:0] x);
        logic [31:0]  r;
        logic [31:0]  t;
        logic [127:0] p;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            p = {96'd0, t} * {96'd0, t};
            if (p <= {64'd0, x})
                r = t;
        end
        return r;
    endfunction

    function automatic wide_t sq_dist(input logic signed [69:0] a[3],
                                      input logic signed [69:0] b[3]);
        logic signed [69:0] d;
        wide_t              s;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = a[i] - b[i];
            s = s + wide_t'(d * d);
        end
        return s;
    endfunction

    // floor(2^FRAC_BITS * sqrt(num/den)), saturated
    function automatic out_t ratio_from(input wide_t num, input wide_t den);
        out_t  r;
        wide_t q;
        r.ratio      = '1;
        r.degenerate = 1'b1;
        if (den == '0)
            return r;
        q = (num << (2 * FRAC_BITS)) / den;
        if ((q >> 64) != '0)
            return r;
        r.ratio      = root64(q[63:0]);
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic out_t aspect_of(input in_t e);
        logic signed [69:0] p0[3];
        logic signed [69:0] p1[3];
        logic signed [69:0] p2[3];
        logic signed [69:0] u[3];
        logic signed [69:0] v[3];
        logic signed [69:0] c;
        wide_t              a;
        wide_t              b;
        wide_t              l;
        wide_t              area2;
        out_t               r;
        p0[0] = $signed(e.x0); p0[1] = $signed(e.y0); p0[2] = $signed(e.z0);
        p1[0] = $signed(e.x1); p1[1] = $signed(e.y1); p1[2] = $signed(e.z1);
        p2[0] = $signed(e.x2); p2[1] = $signed(e.y2); p2[2] = $signed(e.z2);
        r.ratio      = '1;
        r.degenerate = 1'b1;
        case (mode_t'(e.mode))
            MODE_TRI:
            begin
                a = sq_dist(p0, p1);
                b = sq_dist(p0, p2);
                l = sq_dist(p1, p2);
                if (a > l) l = a;
                if (b > l) l = b;
                for (int i = 0; i < 3; i++)
                begin
                    u[i] = p1[i] - p0[i];
                    v[i] = p2[i] - p0[i];
                end
                // squared length of the cross product = (2*area)^2
                area2 = '0;
                c = u[1] * v[2] - u[2] * v[1];
                area2 = area2 + wide_t'(c < 0 ? -c : c) * wide_t'(c < 0 ? -c : c);
                c = u[2] * v[0] - u[0] * v[2];
                area2 = area2 + wide_t'(c < 0 ? -c : c) * wide_t'(c < 0 ? -c : c);
                c = u[0] * v[1] - u[1] * v[0];
                area2 = area2 + wide_t'(c < 0 ? -c : c) * wide_t'(c < 0 ? -c : c);
                r = ratio_from(l * l, area2);
            end
            MODE_RECT:
            begin
                a = sq_dist(p0, p1);
                b = sq_dist(p0, p2);
                r = (a >= b) ? ratio_from(a, b) : ratio_from(b, a);
            end
            MODE_LINE:
            begin
                a = wide_t'(e.diameter);
                r = ratio_from(sq_dist(p0, p1), a * a);
            end
            default: ;
        endcase
        return r;
    endfunction

    // coordinate at a random scale: anywhere in 32 bits, moderate, or a small value shifted left
    function automatic logic [31:0] rand_coord();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return 32'($urandom) ;
        else if (k < 7)
            return 32'(int'($urandom_range(0, 2 << 20)) - (1 << 20));
        else
            return 32'(int'($urandom_range(0, 200)) - 100) <<< $urandom_range(0, 16);
    endfunction

    function automatic in_t rand_elem(input bit sane);
        in_t e;
        e.mode = sane ? 2'($urandom_range(0, 2)) : 2'($urandom);
        e.x0 = rand_coord(); e.y0 = rand_coord(); e.z0 = rand_coord();
        e.x1 = rand_coord(); e.y1 = rand_coord(); e.z1 = rand_coord();
        e.x2 = rand_coord(); e.y2 = rand_coord(); e.z2 = rand_coord();
        case ($urandom_range(0, 3))
            0:       e.diameter = 31'($urandom);
            1:       e.diameter = '0;
            default: e.diameter = 31'($urandom_range(1, 1 << 22));
        endcase
        if (!sane)
        begin
            // collapse some points to hit zero edges and flat triangles
            if ($urandom_range(0, 1)) {e.x1, e.y1, e.z1} = {e.x0, e.y0, e.z0};
            else                      {e.x2, e.y2, e.z2} = {e.x1, e.y1, e.z1};
        end
        return e;
    endfunction

    function automatic in_t make_elem(input mode_t m,
                                      input logic [31:0] ax, ay, az,
                                      input logic [31:0] bx, by, bz,
                                      input logic [31:0] cx, cy, cz,
                                      input logic [30:0] d);
        in_t e;
        e.mode = m;
        e.x0 = ax; e.y0 = ay; e.z0 = az;
        e.x1 = bx; e.y1 = by; e.z1 = bz;
        e.x2 = cx; e.y2 = cy; e.z2 = cz;
        e.diameter = d;
        return e;
    endfunction

    // ---------------------------------------------------------------- driver
    // Inputs change on the falling edge; a transfer is seen on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            ratio_queue.push_back(aspect_of(item));
            taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!push || taken))
        begin
            if (pending_elems.size() != 0 && (calm || $urandom_range(0, 99) >= 30))
            begin
                push <= 1'b1;
                item <= pending_elems.pop_front();
            end
            else
                push <= 1'b0;
        end
        taken = 1'b0;
    end

    // --------------------------------------------------------------- monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (ratio_queue.size() == 0)
            begin
                $display("%0t: unexpected result ratio=%h degenerate=%b",
                         $time, result.ratio, result.degenerate);
                failed = 1'b1;
            end
            else
            begin
                out_t want;
                want = ratio_queue.pop_front();
                if (result.ratio !== want.ratio)
                begin
                    $display("%0t: ratio expected %h actual %h",
                             $time, want.ratio, result.ratio);
                    failed = 1'b1;
                end
                if (result.degenerate !== want.degenerate)
                begin
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degenerate, result.degenerate);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            pop <= calm || $urandom_range(0, 99) >= 30;
    end

    // -------------------------------------------------------------- stimulus
    initial
    begin
        clk    = 1'b0;
        rst_n  = 1'b0;
        push   = 1'b0;
        pop    = 1'b0;
        item   = '0;
        failed = 1'b0;
        calm   = 1'b0;
        taken  = 1'b0;

        // directed: extremes and each corner case
        pending_elems.push_back(make_elem(MODE_TRI, 0, 0, 0, 32'h10000, 0, 0,
                                          0, 32'h10000, 0, 0));
        pending_elems.push_back(make_elem(MODE_TRI, 0, 0, 0, 32'h10000, 0, 0,
                                          32'h20000, 0, 0, 0));   // flat triangle
        pending_elems.push_back(make_elem(MODE_TRI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_elems.push_back(make_elem(MODE_TRI, 32'h80000000, 32'h80000000,
                                          32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                          32'h80000000, '1));
        pending_elems.push_back(make_elem(MODE_TRI, 0, 0, 0, 32'h7fffffff, 0, 0,
                                          0, 1, 0, 0));           // saturates
        pending_elems.push_back(make_elem(MODE_RECT, 0, 0, 0, 32'h30000, 0, 0,
                                          0, 32'h10000, 0, 0));
        pending_elems.push_back(make_elem(MODE_RECT, 0, 0, 0, 32'h30000, 0, 0,
                                          0, 0, 0, 0));           // zero edge
        pending_elems.push_back(make_elem(MODE_RECT, 32'h80000000, 0, 0,
                                          32'h7fffffff, 0, 0, 32'h80000001, 0, 0, 0));
        pending_elems.push_back(make_elem(MODE_RECT, 0, 0, 0, 32'h10000, 0, 0,
                                          0, 0, 32'h10000, 0));   // square
        pending_elems.push_back(make_elem(MODE_LINE, 0, 0, 0, 32'h50000, 0, 0,
                                          0, 0, 0, 31'h10000));
        pending_elems.push_back(make_elem(MODE_LINE, 0, 0, 0, 32'h50000, 0, 0,
                                          0, 0, 0, 0));           // zero diameter
        pending_elems.push_back(make_elem(MODE_LINE, 32'h80000000, 32'h80000000,
                                          32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                          32'h7fffffff, '1, '1, '1, '1));
        pending_elems.push_back(make_elem(MODE_LINE, 32'h80000000, 0, 0,
                                          32'h7fffffff, 0, 0, 0, 0, 0, 31'd1));
        pending_elems.push_back(make_elem(MODE_LINE, 0, 0, 0, 0, 0, 0,
                                          0, 0, 0, 31'd5));       // zero length
        pending_elems.push_back(make_elem(MODE_NONE, 0, 0, 0, 32'h10000, 0, 0,
                                          0, 32'h10000, 0, 31'h10000));
        pending_elems.push_back(make_elem(MODE_NONE, '1, '1, '1, '1, '1, '1,
                                          '1, '1, '1, '1));

        // random: mostly well-formed elements, some collapsed or mode 3
        for (int n = 0; n < 1800; n++)
            pending_elems.push_back(rand_elem($urandom_range(0, 9) < 8));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a stretch with no idling on either side
        wait (pending_elems.size() < 1200);
        calm = 1'b1;
        wait (pending_elems.size() < 900);
        calm = 1'b0;

        wait (pending_elems.size() == 0 && !push);
        wait (ratio_queue.size() == 0);
        repeat (120) @(posedge clk);
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### mesh_element_aspect_ratio.f
sv/mear_pkg.sv
sv/mear_front.sv
sv/mear_queue.sv
sv/mear_back.sv
sv/mesh_element_aspect_ratio.sv
sv/mear_chk.sv
tb/sv/tb_top.sv
